FILE: rtl/fca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_pkg
// Shared widths, register indexes and reset values for the force click
// arbitration core.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned PressW    = 16;
  localparam int unsigned TickW     = 48;
  localparam int unsigned StallW    = 8;
  localparam int unsigned SquareW   = 2 * CoordW;
  localparam int unsigned DistW     = SquareW + 1;
  localparam int unsigned CfgDataW  = TickW;
  localparam int unsigned CfgIndexW = 3;

  // input word: button_down, now_ticks, contact_x, contact_y, contact_pressure
  localparam int unsigned InFieldW  = 1 + TickW + 2 * CoordW + PressW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  // result word: click, force pulse, state, drag lock, frame peak
  localparam int unsigned OutFieldW = 1 + 1 + 2 + 1 + PressW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [CfgIndexW-1:0] {
    CfgForceActive = 3'd0,
    CfgForceThresh = 3'd1,
    CfgTimeout     = 3'd2,
    CfgLockoutDist = 3'd3,
    CfgHysteresis  = 3'd4,
    CfgStallLimit  = 3'd5
  } cfg_index_e;

  localparam logic [PressW-1:0] ForceThreshRst = PressW'(128);
  localparam logic [TickW-1:0]  TimeoutRst     = TickW'(3000000);
  localparam logic [CoordW-1:0] LockoutDistRst = CoordW'(160);
  localparam logic [PressW-1:0] HysteresisRst  = PressW'(4);
  localparam logic [StallW-1:0] StallLimitRst  = StallW'(6);
  localparam logic [StallW-1:0] StallMax       = {StallW{1'b1}};

  // per-contact pipeline payload
  typedef struct packed {
    logic              button_down;
    logic [TickW-1:0]  now_ticks;
    logic              take;
    logic [PressW-1:0] pressure;
    logic              last;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/force_click_arbitration_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// force_click_arbitration_core
// Resolves a touchpad button press to an ordinary click or a force touch from
// a stream of per-contact words, one result word per touch frame.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tdata, tuser = has_contact,
//                                                tlast = last_in_frame
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata, one word per frame end
//  cfg      in   cfg_we_i (no back-pressure)     cfg_index_i, cfg_wdata_i
//
//  One word per cycle sustained while no frame end waits on a held result.
//  A word passes an input register, an abs-diff stage, a squaring stage
//  and the decision stage, which writes a frame's result into the output
//  register. The decision stage (distance add/compare feeding the state
//  update) is the per-word loop that sets the rate.
//  Reset clears all control and tracking state at once; no clearing pass.
//  A waiting result stalls the pipe only when another frame end reaches the
//  decision stage; mid-frame words keep flowing into the tracking state.
//
module force_click_arbitration_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // button_down[0], now_ticks[48:1], contact_x[64:49], contact_y[80:65],
  // contact_pressure[96:81], zero pad above
  input  wire [fca_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire                      s_axis_tuser,   // has_contact
  input  wire                      s_axis_tlast,   // last_in_frame
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  // button_click_report[0], force_touch_click[1], arbitration_state[3:2],
  // drag_locked[4], frame_peak[20:5], zero pad above
  output logic [fca_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  input  wire                      cfg_we_i,
  input  wire [fca_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire [fca_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fca_pkg::*;

  typedef enum logic [1:0] {
    ArbIdle    = 2'd0,
    ArbPending = 2'd1,
    ArbClick   = 2'd2,
    ArbForce   = 2'd3
  } arb_state_e;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic              force_active_q;
  logic [PressW-1:0] force_thresh_q;
  logic [TickW-1:0]  timeout_q;
  logic [CoordW-1:0] lockout_dist_q;
  logic [PressW-1:0] hysteresis_q;
  logic [StallW-1:0] stall_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_active_q <= 1'b0;
      force_thresh_q <= ForceThreshRst;
      timeout_q      <= TimeoutRst;
      lockout_dist_q <= LockoutDistRst;
      hysteresis_q   <= HysteresisRst;
      stall_limit_q  <= StallLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgForceActive: force_active_q <= cfg_wdata_i[0];
        CfgForceThresh: force_thresh_q <= cfg_wdata_i[PressW-1:0];
        CfgTimeout:     timeout_q      <= cfg_wdata_i[TickW-1:0];
        CfgLockoutDist: lockout_dist_q <= cfg_wdata_i[CoordW-1:0];
        CfgHysteresis:  hysteresis_q   <= cfg_wdata_i[PressW-1:0];
        CfgStallLimit:  stall_limit_q  <= cfg_wdata_i[StallW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow: stage 1 input reg, stage 2 abs diffs, stage 3 squares
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3, done3;
  item_t s3_item_q;

  // a mid-frame word never needs the output register
  assign done3  = v3_q && (!s3_item_q.last || !m_axis_tvalid || m_axis_tready);
  assign ready3 = !v3_q || done3;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign s_axis_tready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= s_axis_tvalid;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // stage 1: input register
  item_t             s1_item_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;

  always_ff @(posedge clk_i) begin
    if (ready1 && s_axis_tvalid) begin
      s1_item_q.button_down <= s_axis_tdata[0];
      s1_item_q.now_ticks   <= s_axis_tdata[TickW:1];
      s1_item_q.take        <= s_axis_tuser && s_axis_tdata[0] && force_active_q;
      s1_item_q.pressure    <= s_axis_tdata[TickW+2*CoordW+PressW:TickW+2*CoordW+1];
      s1_item_q.last        <= s_axis_tlast;
      s1_x_q                <= s_axis_tdata[TickW+CoordW:TickW+1];
      s1_y_q                <= s_axis_tdata[TickW+2*CoordW:TickW+CoordW+1];
    end
  end

  // anchor lives here so the next word always sees it
  logic              anchor_valid_q;
  logic [CoordW-1:0] anchor_x_q, anchor_y_q;
  logic [CoordW-1:0] ref_x, ref_y, abs_x, abs_y;
  logic              load2;

  assign load2 = v1_q && ready2;

  always_comb begin
    ref_x = anchor_x_q;
    ref_y = anchor_y_q;
    if (!anchor_valid_q) begin
      ref_x = s1_x_q;
      ref_y = s1_y_q;
    end
    abs_x = (s1_x_q >= ref_x) ? (s1_x_q - ref_x) : (ref_x - s1_x_q);
    abs_y = (s1_y_q >= ref_y) ? (s1_y_q - ref_y) : (ref_y - s1_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_valid_q <= 1'b0;
      anchor_x_q     <= '0;
      anchor_y_q     <= '0;
    end else if (load2) begin
      // frame end with button up or feature off drops the anchor
      if (s1_item_q.last && (!force_active_q || !s1_item_q.button_down)) begin
        anchor_valid_q <= 1'b0;
      end else if (s1_item_q.take && !anchor_valid_q) begin
        anchor_valid_q <= 1'b1;
        anchor_x_q     <= s1_x_q;
        anchor_y_q     <= s1_y_q;
      end
    end
  end

  // stage 2: abs diffs
  item_t             s2_item_q;
  logic [CoordW-1:0] s2_ax_q, s2_ay_q;

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_item_q <= s1_item_q;
      s2_ax_q   <= abs_x;
      s2_ay_q   <= abs_y;
    end
  end

  // stage 3: squares
  logic [CoordW-1:0]  s3_ax_q, s3_ay_q;
  logic [SquareW-1:0] s3_sqx_q, s3_sqy_q;

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) begin
      s3_item_q <= s2_item_q;
      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_sqx_q  <= SquareW'(s2_ax_q) * SquareW'(s2_ax_q);
      s3_sqy_q  <= SquareW'(s2_ay_q) * SquareW'(s2_ay_q);
    end
  end

  // --------------------------------------------------------------------------
  // decision stage: nearest contact, peak, frame-end arbitration
  // --------------------------------------------------------------------------
  arb_state_e        arb_q, arb_d, arb_a;
  logic              lock_q, lock_d;
  logic [TickW-1:0]  press_start_q, press_start_d;
  logic [PressW-1:0] held_peak_q, held_peak_d;
  logic [StallW-1:0] stall_q, stall_d;
  logic [PressW-1:0] run_peak_q, run_peak_d;
  logic              best_valid_q, best_valid_d;
  logic [DistW-1:0]  best_dist_q, best_dist_d;
  logic [CoordW-1:0] best_dx_q, best_dx_d, best_dy_q, best_dy_d;
  logic [DistW-1:0]  dist_sum;
  logic [PressW-1:0] peak;
  logic              click, force_pulse;
  logic [OutDataW-1:0] result;

  always_comb begin
    dist_sum = {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};

    run_peak_d   = run_peak_q;
    best_valid_d = best_valid_q;
    best_dist_d  = best_dist_q;
    best_dx_d    = best_dx_q;
    best_dy_d    = best_dy_q;
    if (s3_item_q.take) begin
      if (s3_item_q.pressure > run_peak_q) run_peak_d = s3_item_q.pressure;
      if (!best_valid_q || dist_sum < best_dist_q) begin
        best_valid_d = 1'b1;
        best_dist_d  = dist_sum;
        best_dx_d    = s3_ax_q;
        best_dy_d    = s3_ay_q;
      end
    end

    arb_d         = arb_q;
    arb_a         = arb_q;
    lock_d        = lock_q;
    press_start_d = press_start_q;
    held_peak_d   = held_peak_q;
    stall_d       = stall_q;
    peak          = run_peak_d;
    click         = 1'b0;
    force_pulse   = 1'b0;

    if (!force_active_q) begin
      // plain pass-through
      lock_d = 1'b0;
      arb_d  = s3_item_q.button_down ? ArbClick : ArbIdle;
      click  = s3_item_q.button_down;
      peak   = '0;
    end else if (!s3_item_q.button_down) begin
      // release frame
      lock_d      = 1'b0;
      force_pulse = (arb_q == ArbForce);
      click       = (arb_q == ArbPending);
      arb_d       = ArbIdle;
    end else begin
      // a frame with any tracked contact has a live anchor
      if (best_valid_d && (best_dx_d > lockout_dist_q || best_dy_d > lockout_dist_q)) begin
        lock_d = 1'b1;
      end
      if (arb_q == ArbIdle) begin
        arb_a         = ArbPending;
        press_start_d = s3_item_q.now_ticks;
        held_peak_d   = peak;
        stall_d       = '0;
      end
      arb_d = arb_a;
      if (lock_d) begin
        arb_d = ArbClick;
      end else if (arb_a == ArbPending) begin
        if (peak > held_peak_d) begin
          held_peak_d = peak;
          stall_d     = '0;
        end else if (stall_d < StallMax) begin
          stall_d = stall_d + StallW'(1);
        end
        if (peak > force_thresh_q) begin
          arb_d = ArbForce;
        end else if ((held_peak_d - peak) >= hysteresis_q) begin
          arb_d = ArbClick;
        end else if (stall_d >= stall_limit_q) begin
          arb_d = ArbClick;
        end else if (s3_item_q.now_ticks >= press_start_d &&
                     (s3_item_q.now_ticks - press_start_d) >= timeout_q) begin
          arb_d = ArbClick;
        end
      end
      if (arb_d == ArbClick) click = 1'b1;
    end

    result = '0;
    result[0]          = click;
    result[1]          = force_pulse;
    result[3:2]        = arb_d;
    result[4]          = lock_d;
    result[PressW+4:5] = peak;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arb_q         <= ArbIdle;
      lock_q        <= 1'b0;
      press_start_q <= '0;
      held_peak_q   <= '0;
      stall_q       <= '0;
      run_peak_q    <= '0;
      best_valid_q  <= 1'b0;
      best_dist_q   <= '0;
      best_dx_q     <= '0;
      best_dy_q     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= (done3 && s3_item_q.last) || (m_axis_tvalid && !m_axis_tready);
      if (done3) begin
        if (s3_item_q.last) begin
          arb_q         <= arb_d;
          lock_q        <= lock_d;
          press_start_q <= press_start_d;
          held_peak_q   <= held_peak_d;
          stall_q       <= stall_d;
          // per-frame tracking starts over
          run_peak_q    <= '0;
          best_valid_q  <= 1'b0;
          best_dx_q     <= '0;
          best_dy_q     <= '0;
        end else begin
          run_peak_q    <= run_peak_d;
          best_valid_q  <= best_valid_d;
          best_dist_q   <= best_dist_d;
          best_dx_q     <= best_dx_d;
          best_dy_q     <= best_dy_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done3 && s3_item_q.last) m_axis_tdata <= result;
  end

`ifndef SYNTH
  // force pulse only comes out on a release frame
  a_force_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[3:2] == ArbIdle))
    else $error("force pulse with non-idle state");

  // a latched drag lockout always resolves to click
  a_lock_is_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[3:2] == ArbClick))
    else $error("drag lock without click state");

  // click and force pulse are exclusive
  a_click_xor_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("click and force pulse in one word");

  // a frame end in the last stage never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && v3_q && s3_item_q.last) |=>
      $stable(m_axis_tdata))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
